### rtl/union_find_engine_core_assert.svh
// Assertion macros shared by the checkers of the union-find engine.
// Depends on nothing; the including file supplies clock, reset and signals.
`ifndef UNION_FIND_ENGINE_CORE_ASSERT_SVH
`define UNION_FIND_ENGINE_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define UFE_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("ufe checker: same-cycle implication failed");

// Next-cycle implication, disabled while reset is asserted.
`define UFE_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("ufe checker: next-cycle implication failed");

`endif

### rtl/ufe_pkg.sv
// Shared types and constants of the union-find engine.
// Depends on nothing; imported by the controller, datapath, top level and checker.
`default_nettype none

package ufe_pkg;

  // Width of node numbers, of the node count register and of the set count.
  localparam int unsigned NODE_W = 11;
  localparam logic [NODE_W-1:0] NODE_COUNT_RST = 11'd1024;

  typedef enum logic [1:0] {
    OP_QUERY = 2'd0,
    OP_MERGE = 2'd1,
    OP_CLEAR = 2'd2
  } ufe_op_e;

  typedef struct packed {
    logic [1:0]        operation;
    logic [NODE_W-1:0] node_a;
    logic [NODE_W-1:0] node_b;
  } ufe_req_t;

  typedef struct packed {
    logic              connected;
    logic              merged;
    logic [NODE_W-1:0] set_count;
    logic              status;
  } ufe_rsp_t;

  // Which kind of result the datapath loads into its output register.
  typedef enum logic [2:0] {
    RSP_NONE   = 3'd0,
    RSP_REJECT = 3'd1,
    RSP_CLEAR  = 3'd2,
    RSP_QUERY  = 3'd3,
    RSP_MERGED = 3'd4
  } ufe_rsp_e;

  typedef struct packed {
    logic     accept;
    logic     sweep_go;
    logic     sweep_step;
    logic     walk_first_a;
    logic     walk_next;
    logic     walk_first_b;
    logic     capture_b;
    logic     link_join;
    logic     link_clear;
    ufe_rsp_e rsp;
  } ufe_cmd_t;

  typedef struct packed {
    logic req_clear;
    logic req_walk;
    logic sweep_last;
    logic root_found;
    logic merge_distinct;
  } ufe_status_t;

endpackage

`default_nettype wire

### rtl/ufe_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
`default_nettype none

module ufe_ram #(
  parameter int unsigned WIDTH = 11,
  parameter int unsigned DEPTH = 1025
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### rtl/ufe_ctrl.sv
// Controller state machine of the union-find engine.
// Depends on ufe_pkg for the command and status structs.
`default_nettype none

module ufe_ctrl
  import ufe_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        cfg_we_i,
  input  ufe_status_t status_i,
  output ufe_cmd_t    cmd_o,
  output logic        busy_o
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_INIT   = 7'b0000010,
    S_CLEAR  = 7'b0000100,
    S_WALK_A = 7'b0001000,
    S_WALK_B = 7'b0010000,
    S_LINK   = 7'b0100000,
    S_SIZE0  = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    cmd_o     = '0;
    cmd_o.rsp = RSP_NONE;
    state_d   = state_q;
    if (cfg_we_i) begin
      // A new node count restarts the clearing pass.
      cmd_o.sweep_go = 1'b1;
      state_d        = S_INIT;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (start_i) begin
            cmd_o.accept = 1'b1;
            if (status_i.req_clear) begin
              cmd_o.sweep_go = 1'b1;
              state_d        = S_CLEAR;
            end else if (status_i.req_walk) begin
              cmd_o.walk_first_a = 1'b1;
              state_d            = S_WALK_A;
            end else begin
              cmd_o.rsp = RSP_REJECT;
            end
          end
        end
        S_INIT, S_CLEAR: begin
          cmd_o.sweep_step = 1'b1;
          if (status_i.sweep_last) begin
            state_d = S_IDLE;
            if (state_q == S_CLEAR) begin
              cmd_o.rsp = RSP_CLEAR;
            end
          end
        end
        S_WALK_A: begin
          if (status_i.root_found) begin
            cmd_o.walk_first_b = 1'b1;
            state_d            = S_WALK_B;
          end else begin
            cmd_o.walk_next = 1'b1;
          end
        end
        S_WALK_B: begin
          if (!status_i.root_found) begin
            cmd_o.walk_next = 1'b1;
          end else if (status_i.merge_distinct) begin
            cmd_o.capture_b = 1'b1;
            state_d         = S_LINK;
          end else begin
            cmd_o.rsp = RSP_QUERY;
            state_d   = S_IDLE;
          end
        end
        S_LINK: begin
          cmd_o.link_join = 1'b1;
          state_d         = S_SIZE0;
        end
        S_SIZE0: begin
          cmd_o.link_clear = 1'b1;
          cmd_o.rsp        = RSP_MERGED;
          state_d          = S_IDLE;
        end
        default: begin
          state_d = S_INIT;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

`default_nettype wire

### rtl/ufe_datapath.sv
// Datapath of the union-find engine: parent and size memories, root walk,
// link logic, set counter and result register. Depends on ufe_pkg and ufe_ram.
`default_nettype none

module ufe_datapath
  import ufe_pkg::*;
#(
  parameter int unsigned MAX_NODES = 1024
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ufe_req_t          req_i,
  input  logic              cfg_we_i,
  input  logic [NODE_W-1:0] cfg_data_i,
  input  ufe_cmd_t          cmd_i,
  output ufe_status_t       status_o,
  output logic              done_o,
  output ufe_rsp_t          rsp_o
);

  localparam int unsigned AW = $clog2(MAX_NODES + 1);

  logic [1:0]        op_q;
  logic [NODE_W-1:0] b_q;
  logic [NODE_W-1:0] node_count_q;
  logic [NODE_W-1:0] sets_left_q;
  logic [NODE_W-1:0] active_n;
  logic [AW-1:0]     v_q, v_d;
  logic [AW-1:0]     steps_q, steps_d;
  logic [AW-1:0]     ra_q, rb_q, sra_q, srb_q;
  logic [AW-1:0]     sweep_q;
  logic [AW-1:0]     rd_addr, parent_rd, size_rd;
  logic              par_we, size_we;
  logic [AW-1:0]     par_waddr, par_wdata, size_waddr, size_wdata;
  logic [AW-1:0]     big, lesser, size_sum;
  logic              is_qm, a_ok, b_ok;
  ufe_rsp_t          rsp_q;
  logic              done_q;

  // Node count in use, clamped to one through MAX_NODES.
  always_comb begin
    if (node_count_q == '0) begin
      active_n = NODE_W'(1);
    end else if (32'(node_count_q) > MAX_NODES) begin
      active_n = NODE_W'(MAX_NODES);
    end else begin
      active_n = node_count_q;
    end
  end

  assign is_qm = (req_i.operation == OP_QUERY) || (req_i.operation == OP_MERGE);
  assign a_ok  = (req_i.node_a != '0) && (req_i.node_a <= active_n);
  assign b_ok  = (req_i.node_b != '0) && (req_i.node_b <= active_n);

  assign status_o.req_clear      = (req_i.operation == OP_CLEAR);
  assign status_o.req_walk       = is_qm && a_ok && b_ok;
  assign status_o.sweep_last     = (sweep_q == AW'(MAX_NODES));
  assign status_o.root_found     = (parent_rd == v_q) || (32'(parent_rd) > MAX_NODES) ||
                                   (steps_q == AW'(MAX_NODES));
  assign status_o.merge_distinct = (op_q == OP_MERGE) && (ra_q != v_q);

  // Root walk: the read address follows the parent link one step a cycle.
  always_comb begin
    rd_addr = v_q;
    v_d     = v_q;
    steps_d = steps_q;
    if (cmd_i.walk_first_a) begin
      rd_addr = AW'(req_i.node_a);
      v_d     = AW'(req_i.node_a);
      steps_d = '0;
    end else if (cmd_i.walk_first_b) begin
      rd_addr = AW'(b_q);
      v_d     = AW'(b_q);
      steps_d = '0;
    end else if (cmd_i.walk_next) begin
      rd_addr = parent_rd;
      v_d     = parent_rd;
      steps_d = steps_q + 1'b1;
    end
  end

  // The smaller set goes under the larger; on a tie node_b's root moves.
  assign big      = (sra_q < srb_q) ? rb_q : ra_q;
  assign lesser   = (sra_q < srb_q) ? ra_q : rb_q;
  assign size_sum = sra_q + srb_q;

  assign par_we     = cmd_i.sweep_step | cmd_i.link_join;
  assign par_waddr  = cmd_i.sweep_step ? sweep_q : lesser;
  assign par_wdata  = cmd_i.sweep_step ? sweep_q : big;
  assign size_we    = cmd_i.sweep_step | cmd_i.link_join | cmd_i.link_clear;
  assign size_waddr = cmd_i.sweep_step ? sweep_q : (cmd_i.link_join ? big : lesser);
  assign size_wdata = cmd_i.sweep_step ? AW'(1) : (cmd_i.link_join ? size_sum : '0);

  ufe_ram #(
    .WIDTH(AW),
    .DEPTH(MAX_NODES + 1)
  ) u_parent_ram (
    .clk_i  (clk_i),
    .we_i   (par_we),
    .waddr_i(par_waddr),
    .wdata_i(par_wdata),
    .raddr_i(rd_addr),
    .rdata_o(parent_rd)
  );

  ufe_ram #(
    .WIDTH(AW),
    .DEPTH(MAX_NODES + 1)
  ) u_size_ram (
    .clk_i  (clk_i),
    .we_i   (size_we),
    .waddr_i(size_waddr),
    .wdata_i(size_wdata),
    .raddr_i(rd_addr),
    .rdata_o(size_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= NODE_COUNT_RST;
      sets_left_q  <= '0;
      sweep_q      <= '0;
      done_q       <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        node_count_q <= cfg_data_i;
      end
      if (cmd_i.sweep_step && status_o.sweep_last) begin
        sets_left_q <= active_n;
      end else if (cmd_i.link_join && (sets_left_q != '0)) begin
        sets_left_q <= sets_left_q - 1'b1;
      end
      if (cmd_i.sweep_go) begin
        sweep_q <= '0;
      end else if (cmd_i.sweep_step) begin
        sweep_q <= sweep_q + 1'b1;
      end
      done_q <= (cmd_i.rsp != RSP_NONE);
    end
  end

  always_ff @(posedge clk_i) begin
    v_q     <= v_d;
    steps_q <= steps_d;
    if (cmd_i.accept) begin
      op_q <= req_i.operation;
      b_q  <= req_i.node_b;
    end
    if (cmd_i.walk_first_b) begin
      ra_q  <= v_q;
      sra_q <= size_rd;
    end
    if (cmd_i.capture_b) begin
      rb_q  <= v_q;
      srb_q <= size_rd;
    end
    case (cmd_i.rsp)
      RSP_REJECT: begin
        rsp_q.connected <= 1'b0;
        rsp_q.merged    <= 1'b0;
        rsp_q.set_count <= sets_left_q;
        rsp_q.status    <= is_qm;
      end
      RSP_CLEAR: begin
        rsp_q.connected <= 1'b0;
        rsp_q.merged    <= 1'b0;
        rsp_q.set_count <= active_n;
        rsp_q.status    <= 1'b0;
      end
      RSP_QUERY: begin
        rsp_q.connected <= (ra_q == v_q);
        rsp_q.merged    <= 1'b0;
        rsp_q.set_count <= sets_left_q;
        rsp_q.status    <= 1'b0;
      end
      RSP_MERGED: begin
        rsp_q.connected <= 1'b0;
        rsp_q.merged    <= 1'b1;
        rsp_q.set_count <= sets_left_q;
        rsp_q.status    <= 1'b0;
      end
      default: begin
        rsp_q <= rsp_q;
      end
    endcase
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

`default_nettype wire

### rtl/union_find_engine_core.sv
// Top level of the union-find engine: controller plus datapath.
// Depends on ufe_pkg, ufe_ctrl, ufe_datapath and ufe_ram.
//
//   channel  | handshake                 | payload
//   ---------+---------------------------+-------------------------------
//   request  | start / busy              | req_i  (ufe_req_t)
//   result   | done_o strobe, one cycle  | rsp_o  (ufe_rsp_t)
//   config   | cfg_valid_i / cfg_ready_o | cfg_data_i (node count)
//
// A query and a merge last longer the deeper the two nodes sit in their trees, since
// each walks from both nodes up to their roots; union by size keeps a depth at most
// log2 of the node count. The single read port of the parent memory lets the walk
// follow one parent link a cycle.
// A rejected request or an unused opcode is answered in the cycle after acceptance.
// A clear, a reset and every node count write run a clearing pass over all
// MAX_NODES + 1 entries of both memories; busy stays high meanwhile.
// The receiver cannot stall, so each result transaction is shown for one cycle.
`default_nettype none

module union_find_engine_core
  import ufe_pkg::*;
#(
  parameter int unsigned MAX_NODES = 1024
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  ufe_req_t          req_i,
  output logic              done_o,
  output ufe_rsp_t          rsp_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [NODE_W-1:0] cfg_data_i
);

  ufe_cmd_t    cmd;
  ufe_status_t status;
  logic        cfg_we;

  // A node count write is taken only while the engine is idle, so no transaction in
  // flight is cut short. A request in the same idle cycle takes precedence and the
  // write is simply held off for that cycle.
  assign cfg_ready_o = ~busy & ~start;
  assign cfg_we      = cfg_valid_i & cfg_ready_o;

  ufe_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .cfg_we_i(cfg_we),
    .status_i(status),
    .cmd_o   (cmd),
    .busy_o  (busy)
  );

  ufe_datapath #(
    .MAX_NODES(MAX_NODES)
  ) u_datapath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (req_i),
    .cfg_we_i  (cfg_we),
    .cfg_data_i(cfg_data_i),
    .cmd_i     (cmd),
    .status_o  (status),
    .done_o    (done_o),
    .rsp_o     (rsp_o)
  );

endmodule

`default_nettype wire

### rtl/ufe_checker.sv
// Port-level checker of the union-find engine, bound to the top level.
// Depends on ufe_pkg and union_find_engine_core_assert.svh.
`default_nettype none
`include "union_find_engine_core_assert.svh"

module ufe_checker
  import ufe_pkg::*;
(
  input logic     clk_i,
  input logic     rst_ni,
  input logic     start,
  input logic     busy,
  input ufe_req_t req_i,
  input logic     done_o,
  input ufe_rsp_t rsp_o,
  input logic     cfg_valid_i,
  input logic     cfg_ready_o
);

  logic req_taken;
  logic clear_req;
  logic zero_a_req;

  assign req_taken  = start && !busy;
  assign clear_req  = req_taken && (req_i.operation == OP_CLEAR);
  assign zero_a_req = req_taken && (req_i.node_a == '0) &&
                      ((req_i.operation == OP_QUERY) || (req_i.operation == OP_MERGE));

  // A node count write always starts the clearing pass.
  `UFE_ASSERT_NXT(a_cfg_starts_clear, clk_i, rst_ni, cfg_valid_i && cfg_ready_o, busy)

  // An accepted clear makes the engine go busy.
  `UFE_ASSERT_NXT(a_clear_goes_busy, clk_i, rst_ni, clear_req, busy)

  // A query or merge with node_a zero is answered at once with an error.
  `UFE_ASSERT_NXT(a_zero_node_rejected, clk_i, rst_ni, zero_a_req, done_o && rsp_o.status)

  // An error result reports neither a shared root nor a merge.
  `UFE_ASSERT_IMP(a_error_clean, clk_i, rst_ni, done_o && rsp_o.status, !rsp_o.connected && !rsp_o.merged)

endmodule

bind union_find_engine_core ufe_checker u_ufe_checker (.*);

`default_nettype wire
